### rtl/llsf_pkg.sv
package llsf_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int MAX_POINTS_HI  = 1024;

    // Job fields are sized for the largest supported set
    localparam int CNT_W = $clog2(MAX_POINTS_HI + 1);
    localparam int S1_W  = 24 + CNT_W;
    localparam int S2_W  = 47 + CNT_W;
    localparam int WW    = 128;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] FIT_OK   = 2'd0;
    localparam logic [1:0] FIT_FEW  = 2'd1;
    localparam logic [1:0] FIT_FLAT = 2'd2;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } op_t;

    typedef struct packed {
        logic                   go;
        op_t                    op;
        logic [WW-1:0]          a;
        logic [WW-1:0]          b;
    } arith_req_t;

    typedef struct packed {
        logic [CNT_W-1:0]       count;
        logic signed [S1_W-1:0] sum_x;
        logic signed [S1_W-1:0] sum_y;
        logic signed [S2_W-1:0] sum_xy;
        logic signed [S2_W-1:0] sum_xx;
        logic signed [S2_W-1:0] sum_yy;
    } job_t;

    typedef struct packed {
        logic [31:0] slope;
        logic [31:0] intercept;
        logic [31:0] pearson_r;
        logic [31:0] residual_error;
        logic [31:0] slope_error;
        logic [31:0] intercept_error;
        logic [1:0]  fit_status;
        logic [6:0]  points_used;
    } fit_t;

    function automatic logic [WW-1:0] abs128(input logic [WW-1:0] v);
        return v[WW-1] ? (~v + 1'b1) : v;
    endfunction

    // Signed saturation of a quotient magnitude with its sign
    function automatic logic [31:0] sat_signed(input logic neg, input logic [WW-1:0] q,
                                               input logic [WW-1:0] nlim,
                                               input logic [WW-1:0] plim);
        logic [31:0] r;
        if (neg && q != '0) begin
            if (q >= nlim) r = ~nlim[31:0] + 1'b1;
            else           r = ~q[31:0] + 1'b1;
        end else begin
            if (q >= plim) r = plim[31:0];
            else           r = q[31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] usat32(input logic [WW-1:0] q);
        return (q[WW-1:32] != '0) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

endpackage

### rtl/linear_least_squares_fit_unit.sv
// Channel   Direction  Transfer when           Payload
// --------  ---------  ----------------------  ---------------------------------------------
// sample    in         start && !busy          x_sample, y_sample, last_point
// result    out        done (one cycle)        slope, intercept, pearson_r, residual_error,
//                                              slope_error, intercept_error, fit_status,
//                                              points_used
//
// Sample pairs transfer one per cycle while a set is being gathered. After the pair
// that carries last_point, busy stays high for the fit, whose length is set by the
// shared bit-serial multiply/divide/root unit (64 to 128 steps per operation) and the
// residual pass over the n stored pairs; a set of fewer than three pairs ends with no
// arithmetic, and one with zero x variance ends after the x, y and xy variance products.
// Reset (rst_n low, asynchronous) clears the count, sums, queue and sequencers; the
// sample RAM keeps no reset. The receiver cannot stall: done pulses for one cycle.
module linear_least_squares_fit_unit #(
    parameter int MAX_POINTS = llsf_pkg::MAX_POINTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [23:0] x_sample,
    input  logic signed [23:0] y_sample,
    input  logic               last_point,
    output logic               done,
    output logic signed [31:0] slope,
    output logic signed [31:0] intercept,
    output logic signed [31:0] pearson_r,
    output logic [31:0]        residual_error,
    output logic [31:0]        slope_error,
    output logic [31:0]        intercept_error,
    output logic [1:0]         fit_status,
    output logic [6:0]         points_used
);

    localparam int AW = $clog2(MAX_POINTS);

    logic                   accept;
    logic                   we;
    logic [AW-1:0]          waddr, raddr;
    logic                   pend, push, pop, q_valid, back_active;
    llsf_pkg::job_t         job_in, job_out;
    logic [23:0]            x_rd, y_rd;
    llsf_pkg::arith_req_t   req;
    logic                   arith_done;
    logic [llsf_pkg::WW-1:0] arith_res;
    llsf_pkg::fit_t         fit;

    // hold off new samples while a set is handed over or being fitted
    assign busy   = pend || q_valid || back_active;
    assign accept = start && !busy;

    llsf_front #(.MAX_POINTS(MAX_POINTS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .x_sample   (x_sample),
        .y_sample   (y_sample),
        .last_point (last_point),
        .we         (we),
        .waddr      (waddr),
        .pend       (pend),
        .push       (push),
        .job        (job_in)
    );

    llsf_ram #(.WIDTH(24), .DEPTH(MAX_POINTS)) u_xram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (x_sample),
        .raddr (raddr),
        .rdata (x_rd)
    );

    llsf_ram #(.WIDTH(24), .DEPTH(MAX_POINTS)) u_yram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (y_sample),
        .raddr (raddr),
        .rdata (y_rd)
    );

    llsf_fifo u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (job_in),
        .pop   (pop),
        .valid (q_valid),
        .dout  (job_out)
    );

    llsf_arith u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .done   (arith_done),
        .result (arith_res)
    );

    llsf_back #(.MAX_POINTS(MAX_POINTS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (q_valid),
        .job        (job_out),
        .job_pop    (pop),
        .active     (back_active),
        .raddr      (raddr),
        .x_rd       (signed'(x_rd)),
        .y_rd       (signed'(y_rd)),
        .req        (req),
        .arith_done (arith_done),
        .arith_res  (arith_res),
        .done       (done),
        .fit        (fit)
    );

    // drive result ports from the back end's registers
    assign slope           = signed'(fit.slope);
    assign intercept       = signed'(fit.intercept);
    assign pearson_r       = signed'(fit.pearson_r);
    assign residual_error  = fit.residual_error;
    assign slope_error     = fit.slope_error;
    assign intercept_error = fit.intercept_error;
    assign fit_status      = fit.fit_status;
    assign points_used     = fit.points_used;

endmodule

### rtl/llsf_ram.sv
module llsf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/llsf_front.sv
module llsf_front #(
    parameter int MAX_POINTS = llsf_pkg::MAX_POINTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic signed [23:0]              x_sample,
    input  logic signed [23:0]              y_sample,
    input  logic                            last_point,
    output logic                            we,
    output logic [$clog2(MAX_POINTS)-1:0]   waddr,
    output logic                            pend,
    output logic                            push,
    output llsf_pkg::job_t                  job
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int S1 = 24 + CW;
    localparam int S2 = 47 + CW;

    logic [CW-1:0]        count_reg;
    logic signed [S1-1:0] sum_x_reg, sum_y_reg;
    logic signed [S2-1:0] sum_xy_reg, sum_xx_reg, sum_yy_reg;
    logic                 pend_reg;
    logic signed [47:0]   pxy, pxx, pyy;
    logic                 room;

    assign pxy   = x_sample * y_sample;
    assign pxx   = x_sample * x_sample;
    assign pyy   = y_sample * y_sample;
    assign room  = count_reg < CW'(MAX_POINTS);
    assign we    = accept && room;
    assign waddr = count_reg[AW-1:0];
    assign pend  = pend_reg;
    assign push  = pend_reg;

    assign job.count  = llsf_pkg::CNT_W'(count_reg);
    assign job.sum_x  = llsf_pkg::S1_W'(sum_x_reg);
    assign job.sum_y  = llsf_pkg::S1_W'(sum_y_reg);
    assign job.sum_xy = llsf_pkg::S2_W'(sum_xy_reg);
    assign job.sum_xx = llsf_pkg::S2_W'(sum_xx_reg);
    assign job.sum_yy = llsf_pkg::S2_W'(sum_yy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            sum_xy_reg <= '0;
            sum_xx_reg <= '0;
            sum_yy_reg <= '0;
            pend_reg   <= 1'b0;
        end
        else if (pend_reg)
        begin
            // hand the set over, then clear for the next one
            count_reg  <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            sum_xy_reg <= '0;
            sum_xx_reg <= '0;
            sum_yy_reg <= '0;
            pend_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (room)
            begin
                count_reg  <= count_reg + 1'b1;
                sum_x_reg  <= sum_x_reg + S1'(x_sample);
                sum_y_reg  <= sum_y_reg + S1'(y_sample);
                sum_xy_reg <= sum_xy_reg + S2'(pxy);
                sum_xx_reg <= sum_xx_reg + S2'(pxx);
                sum_yy_reg <= sum_yy_reg + S2'(pyy);
            end
            pend_reg <= last_point;
        end
    end

endmodule

### rtl/llsf_fifo.sv
module llsf_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  llsf_pkg::job_t din,
    input  logic           pop,
    output logic           valid,
    output llsf_pkg::job_t dout
);

    localparam int PW = $clog2(llsf_pkg::QUEUE_DEPTH);
    localparam int NW = $clog2(llsf_pkg::QUEUE_DEPTH + 1);

    llsf_pkg::job_t mem_reg [llsf_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  wr_reg, rd_reg;
    logic [NW-1:0]  fill_reg;

    assign valid = fill_reg != '0;
    assign dout  = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop)  rd_reg <= rd_reg + 1'b1;
            fill_reg <= fill_reg + NW'(push) - NW'(pop);
        end
    end

endmodule

### rtl/llsf_arith.sv
module llsf_arith (
    input  logic                    clk,
    input  logic                    rst_n,
    input  llsf_pkg::arith_req_t    req,
    output logic                    done,
    output logic [llsf_pkg::WW-1:0] result
);

    localparam int WW = llsf_pkg::WW;

    typedef enum logic [1:0] {
        A_IDLE,
        A_RUN,
        A_FIN
    } astate_t;

    astate_t         state_reg;
    llsf_pkg::op_t   op_reg;
    logic [6:0]      cnt_reg;
    logic [WW-1:0]   acc_reg, sh_reg, aux_reg, result_reg;
    logic            neg_reg, done_reg;

    logic [WW-1:0]   acc_next, sh_next, aux_next;
    logic [WW:0]     drem, ddiff;
    logic            dge;
    logic [67:0]     srem, strial;
    logic            sge;
    logic [63:0]     ma, mb;

    assign ma     = req.a[63] ? (~req.a[63:0] + 1'b1) : req.a[63:0];
    assign mb     = req.b[63] ? (~req.b[63:0] + 1'b1) : req.b[63:0];
    assign drem   = {acc_reg, sh_reg[WW-1]};
    assign ddiff  = drem - {1'b0, aux_reg};
    assign dge    = drem >= {1'b0, aux_reg};
    assign srem   = {acc_reg[65:0], sh_reg[WW-1:WW-2]};
    assign strial = {2'b00, aux_reg[63:0], 2'b01};
    assign sge    = srem >= strial;

    // one shift-add, restoring-divide or root-digit step per cycle
    always_comb
    begin
        acc_next = acc_reg;
        sh_next  = sh_reg;
        aux_next = aux_reg;
        unique case (op_reg)
            llsf_pkg::OP_MUL:
            begin
                acc_next = aux_reg[0] ? acc_reg + sh_reg : acc_reg;
                sh_next  = sh_reg << 1;
                aux_next = aux_reg >> 1;
            end
            llsf_pkg::OP_DIV:
            begin
                acc_next = dge ? ddiff[WW-1:0] : drem[WW-1:0];
                sh_next  = {sh_reg[WW-2:0], dge};
            end
            llsf_pkg::OP_SQRT:
            begin
                acc_next = WW'(sge ? srem - strial : srem);
                sh_next  = sh_reg << 2;
                aux_next = {64'b0, aux_reg[62:0], sge};
            end
            default: ;
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                A_IDLE:
                begin
                    if (req.go)
                    begin
                        op_reg  <= req.op;
                        acc_reg <= '0;
                        neg_reg <= req.a[63] ^ req.b[63];
                        unique case (req.op)
                            llsf_pkg::OP_MUL:
                            begin
                                sh_reg  <= WW'(ma);
                                aux_reg <= WW'(mb);
                                cnt_reg <= 7'd63;
                            end
                            llsf_pkg::OP_DIV:
                            begin
                                sh_reg  <= req.a;
                                aux_reg <= req.b;
                                cnt_reg <= 7'd127;
                            end
                            default:
                            begin
                                sh_reg  <= req.a;
                                aux_reg <= '0;
                                cnt_reg <= 7'd63;
                            end
                        endcase
                        state_reg <= A_RUN;
                    end
                end
                A_RUN:
                begin
                    acc_reg <= acc_next;
                    sh_reg  <= sh_next;
                    aux_reg <= aux_next;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) state_reg <= A_FIN;
                end
                A_FIN:
                begin
                    unique case (op_reg)
                        llsf_pkg::OP_MUL:  result_reg <= neg_reg ? (~acc_reg + 1'b1) : acc_reg;
                        llsf_pkg::OP_DIV:  result_reg <= sh_reg;
                        default:           result_reg <= {64'b0, aux_reg[63:0]};
                    endcase
                    done_reg  <= 1'b1;
                    state_reg <= A_IDLE;
                end
                default: state_reg <= A_IDLE;
            endcase
        end
    end

endmodule

### rtl/llsf_back.sv
module llsf_back #(
    parameter int MAX_POINTS = llsf_pkg::MAX_POINTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            job_valid,
    input  llsf_pkg::job_t                  job,
    output logic                            job_pop,
    output logic                            active,
    output logic [$clog2(MAX_POINTS)-1:0]   raddr,
    input  logic signed [23:0]              x_rd,
    input  logic signed [23:0]              y_rd,
    output llsf_pkg::arith_req_t            req,
    input  logic                            arith_done,
    input  logic [llsf_pkg::WW-1:0]         arith_res,
    output logic                            done,
    output llsf_pkg::fit_t                  fit
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int WW = llsf_pkg::WW;

    typedef enum logic [4:0] {
        B_IDLE, B_PREP,
        B_M_NXX, B_M_SXX, B_M_NYY, B_M_SYY, B_M_NXY, B_M_SXY, B_CHK,
        B_M_SYXX, B_M_SXXY, B_D_A, B_D_B, B_Q_DXX, B_Q_DYY, B_M_DEN, B_D_R,
        B_RD, B_AX, B_ERR, B_M_SQ,
        B_D_SSE, B_Q_EPS, B_Q_SD, B_Q_N, B_M_SE, B_D_SE, B_Q_XX, B_M_IE, B_D_IE,
        B_FIN
    } bstate_t;

    bstate_t                      state_reg;
    logic                         wait_reg, done_reg;
    llsf_pkg::job_t               job_reg;
    logic [WW-1:0]                p_reg, dxx_reg, dyy_reg, dxy_reg, num_reg, den_reg, t_reg;
    logic [WW-1:0]                sse_reg;
    logic [63:0]                  sdx_reg, sdy_reg, eps_reg, sd_reg, ue_reg;
    logic signed [55:0]           ax_reg;
    logic [llsf_pkg::CNT_W-1:0]   i_reg;
    logic signed [31:0]           slope_reg, icept_reg;
    logic [31:0]                  r_reg, res_reg, serr_reg, ierr_reg;
    logic [1:0]                   status_reg;
    logic [6:0]                   used_reg;

    logic [WW-1:0]      n_w, sx_w, sy_w, sxy_w, sxx_w, syy_w;
    logic [WW-1:0]      dxy16, num4, dxy30;
    logic               issue;
    logic signed [55:0] ax_next;
    logic signed [63:0] e_val;

    assign n_w   = WW'(job_reg.count);
    assign sx_w  = WW'(job_reg.sum_x);
    assign sy_w  = WW'(job_reg.sum_y);
    assign sxy_w = WW'(job_reg.sum_xy);
    assign sxx_w = WW'(job_reg.sum_xx);
    assign syy_w = WW'(job_reg.sum_yy);
    assign dxy16 = dxy_reg << 16;
    assign num4  = num_reg << 4;
    assign dxy30 = dxy_reg << 30;

    assign ax_next = slope_reg * x_rd;
    assign e_val   = (64'(y_rd) <<< 16) - 64'(ax_reg) - (64'(icept_reg) <<< 12);

    assign raddr   = i_reg[AW-1:0];
    assign job_pop = (state_reg == B_IDLE) && job_valid;
    assign active  = state_reg != B_IDLE;
    assign done    = done_reg;

    assign fit.slope           = slope_reg;
    assign fit.intercept       = icept_reg;
    assign fit.pearson_r       = r_reg;
    assign fit.residual_error  = res_reg;
    assign fit.slope_error     = serr_reg;
    assign fit.intercept_error = ierr_reg;
    assign fit.fit_status      = status_reg;
    assign fit.points_used     = used_reg;

    // operand select for the shared arithmetic unit
    always_comb
    begin
        issue = 1'b1;
        req.op = llsf_pkg::OP_MUL;
        req.a  = '0;
        req.b  = '0;
        unique case (state_reg)
            B_M_NXX:  begin req.a = n_w;  req.b = sxx_w; end
            B_M_SXX:  begin req.a = sx_w; req.b = sx_w;  end
            B_M_NYY:  begin req.a = n_w;  req.b = syy_w; end
            B_M_SYY:  begin req.a = sy_w; req.b = sy_w;  end
            B_M_NXY:  begin req.a = n_w;  req.b = sxy_w; end
            B_M_SXY:  begin req.a = sx_w; req.b = sy_w;  end
            B_M_SYXX: begin req.a = sy_w; req.b = sxx_w; end
            B_M_SXXY: begin req.a = sx_w; req.b = sxy_w; end
            B_D_A:    begin req.op = llsf_pkg::OP_DIV; req.a = llsf_pkg::abs128(dxy16);
                            req.b = dxx_reg; end
            B_D_B:    begin req.op = llsf_pkg::OP_DIV; req.a = llsf_pkg::abs128(num4);
                            req.b = dxx_reg; end
            B_Q_DXX:  begin req.op = llsf_pkg::OP_SQRT; req.a = dxx_reg; end
            B_Q_DYY:  begin req.op = llsf_pkg::OP_SQRT; req.a = dyy_reg; end
            B_M_DEN:  begin req.a = WW'(sdx_reg); req.b = WW'(sdy_reg); end
            B_D_R:    begin req.op = llsf_pkg::OP_DIV; req.a = llsf_pkg::abs128(dxy30);
                            req.b = den_reg; end
            B_M_SQ:   begin req.a = WW'(ue_reg); req.b = WW'(ue_reg); end
            B_D_SSE:  begin req.op = llsf_pkg::OP_DIV; req.a = sse_reg; req.b = n_w - WW'(2); end
            B_Q_EPS:  begin req.op = llsf_pkg::OP_SQRT; req.a = t_reg; end
            B_Q_SD:   begin req.op = llsf_pkg::OP_SQRT; req.a = dxx_reg << 32; end
            B_Q_N:    begin req.op = llsf_pkg::OP_SQRT; req.a = n_w << 32; end
            B_M_SE:   begin req.a = WW'(eps_reg); req.b = t_reg; end
            B_D_SE:   begin req.op = llsf_pkg::OP_DIV; req.a = p_reg; req.b = WW'(sd_reg); end
            B_Q_XX:   begin req.op = llsf_pkg::OP_SQRT; req.a = sxx_w << 32; end
            B_M_IE:   begin req.a = WW'(eps_reg); req.b = t_reg; end
            B_D_IE:   begin req.op = llsf_pkg::OP_DIV; req.a = p_reg;
                            req.b = WW'(sd_reg) << 12; end
            default:  issue = 1'b0;
        endcase
        req.go = issue && !wait_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            wait_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.go)     wait_reg <= 1'b1;
            if (arith_done) wait_reg <= 1'b0;
            unique case (state_reg)
                B_IDLE:
                begin
                    if (job_valid)
                    begin
                        job_reg   <= job;
                        state_reg <= B_PREP;
                    end
                end
                B_PREP:
                begin
                    slope_reg  <= '0;
                    icept_reg  <= '0;
                    r_reg      <= '0;
                    res_reg    <= '0;
                    serr_reg   <= '0;
                    ierr_reg   <= '0;
                    status_reg <= llsf_pkg::FIT_OK;
                    used_reg   <= job_reg.count[6:0];
                    if (job_reg.count < llsf_pkg::CNT_W'(3))
                    begin
                        status_reg <= llsf_pkg::FIT_FEW;
                        state_reg  <= B_FIN;
                    end
                    else
                    begin
                        state_reg <= B_M_NXX;
                    end
                end
                B_M_NXX: if (arith_done) begin p_reg <= arith_res; state_reg <= B_M_SXX; end
                B_M_SXX: if (arith_done) begin dxx_reg <= p_reg - arith_res;
                                               state_reg <= B_M_NYY; end
                B_M_NYY: if (arith_done) begin p_reg <= arith_res; state_reg <= B_M_SYY; end
                B_M_SYY: if (arith_done) begin dyy_reg <= p_reg - arith_res;
                                               state_reg <= B_M_NXY; end
                B_M_NXY: if (arith_done) begin p_reg <= arith_res; state_reg <= B_M_SXY; end
                B_M_SXY: if (arith_done) begin dxy_reg <= p_reg - arith_res;
                                               state_reg <= B_CHK; end
                B_CHK:
                begin
                    i_reg   <= '0;
                    sse_reg <= '0;
                    if (dxx_reg == '0)
                    begin
                        status_reg <= llsf_pkg::FIT_FLAT;
                        state_reg  <= B_FIN;
                    end
                    else
                    begin
                        state_reg <= B_M_SYXX;
                    end
                end
                B_M_SYXX: if (arith_done) begin p_reg <= arith_res; state_reg <= B_M_SXXY; end
                B_M_SXXY: if (arith_done) begin num_reg <= p_reg - arith_res;
                                                state_reg <= B_D_A; end
                B_D_A:
                if (arith_done)
                begin
                    slope_reg <= llsf_pkg::sat_signed(dxy16[WW-1], arith_res,
                                                      WW'(32'h8000_0000), WW'(32'h7FFF_FFFF));
                    state_reg <= B_D_B;
                end
                B_D_B:
                if (arith_done)
                begin
                    icept_reg <= llsf_pkg::sat_signed(num4[WW-1], arith_res,
                                                      WW'(32'h8000_0000), WW'(32'h7FFF_FFFF));
                    state_reg <= B_Q_DXX;
                end
                B_Q_DXX: if (arith_done) begin sdx_reg <= arith_res[63:0];
                                               state_reg <= B_Q_DYY; end
                B_Q_DYY: if (arith_done) begin sdy_reg <= arith_res[63:0];
                                               state_reg <= B_M_DEN; end
                B_M_DEN:
                if (arith_done)
                begin
                    den_reg <= arith_res;
                    // flat y: leave r at zero
                    state_reg <= (arith_res == '0) ? B_RD : B_D_R;
                end
                B_D_R:
                if (arith_done)
                begin
                    r_reg <= llsf_pkg::sat_signed(dxy30[WW-1], arith_res,
                                                  WW'(32'h4000_0000), WW'(32'h4000_0000));
                    state_reg <= B_RD;
                end
                B_RD:  state_reg <= B_AX;
                B_AX:
                begin
                    ax_reg    <= ax_next;
                    state_reg <= B_ERR;
                end
                B_ERR:
                begin
                    ue_reg    <= e_val[63] ? (~e_val + 1'b1) : e_val;
                    state_reg <= B_M_SQ;
                end
                B_M_SQ:
                if (arith_done)
                begin
                    sse_reg <= sse_reg + arith_res;
                    i_reg   <= i_reg + 1'b1;
                    state_reg <= (i_reg + 1'b1 == job_reg.count) ? B_D_SSE : B_RD;
                end
                B_D_SSE: if (arith_done) begin t_reg <= arith_res; state_reg <= B_Q_EPS; end
                B_Q_EPS:
                if (arith_done)
                begin
                    eps_reg   <= arith_res[63:0];
                    res_reg   <= (arith_res[63:44] != '0) ? 32'hFFFF_FFFF : arith_res[43:12];
                    state_reg <= B_Q_SD;
                end
                B_Q_SD:  if (arith_done) begin sd_reg <= arith_res[63:0]; state_reg <= B_Q_N; end
                B_Q_N:   if (arith_done) begin t_reg <= arith_res; state_reg <= B_M_SE; end
                B_M_SE:  if (arith_done) begin p_reg <= arith_res; state_reg <= B_D_SE; end
                B_D_SE:  if (arith_done) begin serr_reg <= llsf_pkg::usat32(arith_res);
                                               state_reg <= B_Q_XX; end
                B_Q_XX:  if (arith_done) begin t_reg <= arith_res; state_reg <= B_M_IE; end
                B_M_IE:  if (arith_done) begin p_reg <= arith_res; state_reg <= B_D_IE; end
                B_D_IE:  if (arith_done) begin ierr_reg <= llsf_pkg::usat32(arith_res);
                                               state_reg <= B_FIN; end
                B_FIN:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= B_IDLE;
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

endmodule

### test/tb_linear_least_squares_fit_unit.sv
`timescale 1ns / 1ps

module tb_linear_least_squares_fit_unit;

    localparam int MAX_PTS      = 64;
    localparam int TARGET_ITEMS = 1850;
    localparam int TAIL_CYCLES  = 8000;   // longer than one fit of a full set

    localparam logic signed [23:0] X_MIN = 24'sh800000;
    localparam logic signed [23:0] X_MAX = 24'sh7FFFFF;

    // Shapes of a random sample set
    typedef enum int {
        SHAPE_WIDE,
        SHAPE_NARROW,
        SHAPE_LINE,
        SHAPE_FLAT_X,
        SHAPE_FLAT_Y
    } shape_t;

    // One directed row: a sample transfer plus, where it can be read off at a
    // glance, the fit that it must produce
    typedef struct {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic               last;
        logic               typed;
        llsf_pkg::fit_t     fit;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [23:0] x_sample;
    logic signed [23:0] y_sample;
    logic               last_point;
    logic               done;
    logic signed [31:0] slope;
    logic signed [31:0] intercept;
    logic signed [31:0] pearson_r;
    logic [31:0]        residual_error;
    logic [31:0]        slope_error;
    logic [31:0]        intercept_error;
    logic [1:0]         fit_status;
    logic [6:0]         points_used;

    linear_least_squares_fit_unit u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .x_sample        (x_sample),
        .y_sample        (y_sample),
        .last_point      (last_point),
        .done            (done),
        .slope           (slope),
        .intercept       (intercept),
        .pearson_r       (pearson_r),
        .residual_error  (residual_error),
        .slope_error     (slope_error),
        .intercept_error (intercept_error),
        .fit_status      (fit_status),
        .points_used     (points_used)
    );

    // ------------------------------------------------------------------
    // Clock: 20 ns period
    // ------------------------------------------------------------------
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the block state: stored pairs and running sums
    // ------------------------------------------------------------------
    logic signed [23:0] set_x [MAX_PTS];
    logic signed [23:0] set_y [MAX_PTS];
    int                 set_count;
    longint             acc_x, acc_y, acc_xy, acc_xx, acc_yy;

    llsf_pkg::fit_t fit_q [$];          // fits still owed by the block
    int   mismatches;
    int   fits_checked;
    int   items_sent;
    int   sets_sent;
    int   full_sets;
    bit   idle_ok;

    // Floor square root of a 128-bit unsigned value
    function automatic logic [63:0] root128(input logic [127:0] v);
        logic [63:0]  r;
        logic [127:0] t;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            t = {64'b0, r | (64'd1 << b)};
            if (t * t <= v)
                r = t[63:0];
        end
        return r;
    endfunction

    // Saturate a signed 128-bit quotient to [-nlim, plim]
    function automatic logic [31:0] clamp32(input logic signed [127:0] v,
                                            input logic [127:0] nlim,
                                            input logic [127:0] plim);
        logic [127:0] m;
        if (v < 0)
        begin
            m = -v;
            if (m >= nlim)
                return -nlim[31:0];
            return -m[31:0];
        end
        m = v;
        if (m >= plim)
            return plim[31:0];
        return m[31:0];
    endfunction

    function automatic logic [31:0] usat(input logic [127:0] v);
        return (v[127:32] != '0) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    // Absorb one sample pair; on the last pair of a set, solve the fit
    function automatic bit absorb_sample(input logic signed [23:0] x,
                                         input logic signed [23:0] y,
                                         input logic last, output llsf_pkg::fit_t fit);
        logic signed [127:0] n, sx, sy, sxy, sxx, syy;
        logic signed [127:0] dxx, dyy, dxy, num, den_s;
        logic [127:0]        den, sse, eps, sd, p;
        longint              a, b, e, ue;
        llsf_pkg::fit_t      f;
        f = '0;
        if (set_count < MAX_PTS)
        begin
            set_x[set_count] = x;
            set_y[set_count] = y;
            set_count++;
            acc_x  += longint'(x);
            acc_y  += longint'(y);
            acc_xy += longint'(x) * longint'(y);
            acc_xx += longint'(x) * longint'(x);
            acc_yy += longint'(y) * longint'(y);
        end
        if (!last)
            return 1'b0;

        n = 128'(set_count);
        sx = 128'(acc_x); sy = 128'(acc_y); sxy = 128'(acc_xy);
        sxx = 128'(acc_xx); syy = 128'(acc_yy);
        f.points_used = set_count[6:0];
        if (set_count < 3)
            f.fit_status = llsf_pkg::FIT_FEW;
        else
        begin
            dxx = n * sxx - sx * sx;
            dyy = n * syy - sy * sy;
            dxy = n * sxy - sx * sy;
            if (dxx == 0)
                f.fit_status = llsf_pkg::FIT_FLAT;
            else
            begin
                f.fit_status = llsf_pkg::FIT_OK;
                f.slope = clamp32((dxy <<< 16) / dxx, 128'h8000_0000, 128'h7FFF_FFFF);
                num = sy * sxx - sx * sxy;
                f.intercept = clamp32((num <<< 4) / dxx, 128'h8000_0000, 128'h7FFF_FFFF);
                den = {64'b0, root128(dxx)} * {64'b0, root128(dyy)};
                den_s = den;
                if (den != 0)
                    f.pearson_r = clamp32((dxy <<< 30) / den_s,
                                          128'h4000_0000, 128'h4000_0000);
                // Residual pass with the saturated slope and intercept
                a = longint'(signed'(f.slope));
                b = longint'(signed'(f.intercept));
                sse = '0;
                for (int i = 0; i < set_count; i++)
                begin
                    e  = longint'(set_y[i]) * 65536 - a * longint'(set_x[i]) - b * 4096;
                    ue = (e < 0) ? -e : e;
                    sse += {64'b0, ue} * {64'b0, ue};
                end
                eps = {64'b0, root128(sse / 128'(set_count - 2))};
                f.residual_error = usat(eps >> 12);
                sd = {64'b0, root128(dxx << 32)};
                p = eps * {64'b0, root128(n << 32)};
                f.slope_error = usat(p / sd);
                p = eps * {64'b0, root128(sxx << 32)};
                f.intercept_error = usat(p / (sd << 12));
            end
        end
        set_count = 0;
        acc_x = 0; acc_y = 0; acc_xy = 0; acc_xx = 0; acc_yy = 0;
        fit = f;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Sample driver: change inputs at the falling edge, hold until the
    // block takes the transfer at a rising edge with busy low
    // ------------------------------------------------------------------
    task automatic send_sample(input logic signed [23:0] x, input logic signed [23:0] y,
                               input logic last, input bit typed,
                               input llsf_pkg::fit_t typed_fit);
        llsf_pkg::fit_t f;
        @(negedge clk);
        if (idle_ok && $urandom_range(99, 0) < 33)
        begin
            // drop start for a short gap before this transfer
            start <= 1'b0;
            repeat ($urandom_range(3, 1) - 1)
                @(negedge clk);
            @(negedge clk);
        end
        start      <= 1'b1;
        x_sample   <= x;
        y_sample   <= y;
        last_point <= last;
        do
            @(posedge clk);
        while (busy);
        if (absorb_sample(x, y, last, f))
        begin
            fit_q.push_back(typed ? typed_fit : f);
            sets_sent++;
        end
        items_sent++;
    endtask

    function automatic logic signed [23:0] sat24(input longint v);
        if (v > 64'sd8388607)
            return X_MAX;
        if (v < -64'sd8388608)
            return X_MIN;
        return v[23:0];
    endfunction

    // Random set of the given size and shape; the last pair closes it
    task automatic send_set(input int size, input shape_t shape);
        logic signed [23:0] x, y, x0, y0;
        longint             k;
        llsf_pkg::fit_t     none;
        none = '0;
        x0 = 24'($urandom);
        y0 = 24'($urandom);
        k  = longint'($urandom_range(4095, 0)) - 2048;
        for (int i = 0; i < size; i++)
        begin
            x = 24'($urandom);
            y = 24'($urandom);
            case (shape)
                SHAPE_NARROW:
                begin
                    x = 24'(longint'($urandom_range(8191, 0)) - 4096);
                    y = 24'(longint'($urandom_range(8191, 0)) - 4096);
                end
                SHAPE_LINE:
                begin
                    x = 24'(longint'($urandom_range(2097151, 0)) - 1048576);
                    y = sat24((k * longint'(x)) / 256 + longint'($urandom_range(511, 0)) - 256);
                end
                SHAPE_FLAT_X: x = x0;
                SHAPE_FLAT_Y: y = y0;
                default: ;
            endcase
            send_sample(x, y, (i == size - 1), 1'b0, none);
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker: every done pulse is one transfer, compared against
    // the oldest fit owed
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got, inout bit bad);
        if (want !== got)
        begin
            bad = 1'b1;
            if (mismatches < 10)
                $display("  %s: expected %h, got %h", name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        llsf_pkg::fit_t want;
        bit   bad;
        if (rst_n && done)
        begin
            bad = 1'b0;
            if (fit_q.size() == 0)
            begin
                if (mismatches < 10)
                    $display("fit result at %0t with none pending", $realtime);
                mismatches++;
            end
            else
            begin
                want = fit_q.pop_front();
                check_field("slope", want.slope, slope, bad);
                check_field("intercept", want.intercept, intercept, bad);
                check_field("pearson_r", want.pearson_r, pearson_r, bad);
                check_field("residual_error", want.residual_error, residual_error, bad);
                check_field("slope_error", want.slope_error, slope_error, bad);
                check_field("intercept_error", want.intercept_error, intercept_error, bad);
                check_field("fit_status", 32'(want.fit_status), 32'(fit_status), bad);
                check_field("points_used", 32'(want.points_used), 32'(points_used), bad);
                if (bad)
                begin
                    if (mismatches < 10)
                        $display("fit mismatch above at %0t (fit %0d)", $realtime,
                                 fits_checked);
                    mismatches++;
                end
                fits_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    row_t rows [$];

    task automatic add_row(input logic signed [23:0] x, input logic signed [23:0] y,
                           input logic last, input logic [1:0] status,
                           input logic [6:0] pts, input bit typed);
        row_t r;
        r.x = x;
        r.y = y;
        r.last = last;
        r.typed = typed;
        r.fit = '0;
        r.fit.fit_status = status;
        r.fit.points_used = pts;
        rows.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int     size;
        shape_t shape;
        int     pick;

        rst_n = 1'b0;
        start = 1'b0;
        x_sample = '0;
        y_sample = '0;
        last_point = 1'b0;
        set_count = 0;
        acc_x = 0; acc_y = 0; acc_xy = 0; acc_xx = 0; acc_yy = 0;
        mismatches = 0;
        fits_checked = 0;
        items_sent = 0;
        sets_sent = 0;
        full_sets = 0;
        idle_ok = 1'b1;
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // A single pair: too few points
        add_row(X_MAX, X_MIN, 1'b1, llsf_pkg::FIT_FEW, 7'd1, 1'b1);
        // Two pairs: still too few
        add_row(X_MIN, X_MAX, 1'b0, llsf_pkg::FIT_OK, 7'd0, 1'b0);
        add_row(24'sd0, 24'sd0, 1'b1, llsf_pkg::FIT_FEW, 7'd2, 1'b1);
        // Constant x: zero x variance
        add_row(24'sd100, 24'sd1, 1'b0, llsf_pkg::FIT_OK, 7'd0, 1'b0);
        add_row(24'sd100, 24'sd2, 1'b0, llsf_pkg::FIT_OK, 7'd0, 1'b0);
        add_row(24'sd100, 24'sd3, 1'b1, llsf_pkg::FIT_FLAT, 7'd3, 1'b1);
        // Constant y: zero y variance, correlation forced to zero
        add_row(24'sd4096, 24'sd5, 1'b0, llsf_pkg::FIT_OK, 7'd0, 1'b0);
        add_row(24'sd8192, 24'sd5, 1'b0, llsf_pkg::FIT_OK, 7'd0, 1'b0);
        add_row(24'sd12288, 24'sd5, 1'b1, llsf_pkg::FIT_OK, 7'd0, 1'b0);
        // Field extremes
        add_row(X_MIN, X_MIN, 1'b0, llsf_pkg::FIT_OK, 7'd0, 1'b0);
        add_row(X_MAX, X_MAX, 1'b0, llsf_pkg::FIT_OK, 7'd0, 1'b0);
        add_row(24'sd0, X_MIN, 1'b0, llsf_pkg::FIT_OK, 7'd0, 1'b0);
        add_row(X_MAX, 24'sd0, 1'b1, llsf_pkg::FIT_OK, 7'd0, 1'b0);
        // Steep line: slope saturates
        add_row(24'sd0, X_MIN, 1'b0, llsf_pkg::FIT_OK, 7'd0, 1'b0);
        add_row(24'sd1, 24'sd0, 1'b0, llsf_pkg::FIT_OK, 7'd0, 1'b0);
        add_row(24'sd2, X_MAX, 1'b1, llsf_pkg::FIT_OK, 7'd0, 1'b0);
        // Exact line y = 2x + 1
        add_row(24'sd0, 24'sd4096, 1'b0, llsf_pkg::FIT_OK, 7'd0, 1'b0);
        add_row(24'sd4096, 24'sd12288, 1'b0, llsf_pkg::FIT_OK, 7'd0, 1'b0);
        add_row(24'sd8192, 24'sd20480, 1'b0, llsf_pkg::FIT_OK, 7'd0, 1'b0);
        add_row(-24'sd4096, -24'sd4096, 1'b1, llsf_pkg::FIT_OK, 7'd0, 1'b0);

        foreach (rows[i])
            send_sample(rows[i].x, rows[i].y, rows[i].last, rows[i].typed, rows[i].fit);

        // Overfilled set: pairs past the store depth are dropped
        send_set(MAX_PTS + 6, SHAPE_WIDE);
        full_sets++;

        // Random sets, mostly small; a few fill the store
        while (items_sent < TARGET_ITEMS)
        begin
            idle_ok = !(items_sent > 700 && items_sent < 1000);
            pick = $urandom_range(99, 0);
            if (pick < 4)
            begin
                size = $urandom_range(MAX_PTS + 4, MAX_PTS - 2);
                if (size >= MAX_PTS)
                    full_sets++;
            end
            else if (pick < 14)
                size = $urandom_range(40, 13);
            else
                size = $urandom_range(12, 1);
            pick = $urandom_range(99, 0);
            if (pick < 40)
                shape = SHAPE_WIDE;
            else if (pick < 60)
                shape = SHAPE_LINE;
            else if (pick < 80)
                shape = SHAPE_NARROW;
            else if (pick < 90)
                shape = SHAPE_FLAT_X;
            else
                shape = SHAPE_FLAT_Y;
            send_set(size, shape);
        end

        @(negedge clk);
        start <= 1'b0;
        last_point <= 1'b0;

        // Drain outstanding fits, then let the block settle
        while (fit_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES)
            @(posedge clk);

        $display("%0d sample transfers in %0d sets (%0d at or past store depth)",
                 items_sent, sets_sent, full_sets);
        $display("%0d fits checked, %0d mismatching", fits_checked, mismatches);
        if (mismatches == 0 && fit_q.size() == 0)
            $display("** linear_least_squares_fit_unit: PASSED **");
        else
            $display("** linear_least_squares_fit_unit: FAILED **");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #400_000_000;
        $display("timeout with %0d fits pending", fit_q.size());
        $display("** linear_least_squares_fit_unit: FAILED **");
        $finish;
    end

endmodule

### files.f
rtl/llsf_pkg.sv
rtl/llsf_ram.sv
rtl/llsf_front.sv
rtl/llsf_fifo.sv
rtl/llsf_arith.sv
rtl/llsf_back.sv
rtl/linear_least_squares_fit_unit.sv
test/tb_linear_least_squares_fit_unit.sv
